// ----- hdl/frame_store_alpha_blend_defines.svh -----
`ifndef FRAME_STORE_ALPHA_BLEND_DEFINES_SVH
`define FRAME_STORE_ALPHA_BLEND_DEFINES_SVH

// cond holds at this edge, so prop holds at the same edge
`define FSAB_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("fsab check failed");

// cond holds at this edge, so prop holds at the next edge
`define FSAB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("fsab check failed");

`endif

// ----- hdl/fsab_pkg.sv -----
`timescale 1ns / 1ps

package fsab_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NUM_CH      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // input function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_BLEND = 2'd2;

    // classified operation carried to the back end
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;
    localparam logic [1:0] OP_DROP  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_CHANNELS = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y = 3'd4;
    localparam logic [2:0] REG_FACTOR   = 3'd5;

    localparam logic [8:0] FACTOR_ONE = 9'd256;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       src;   // r in bits 7..0 up to a in 31..24
        logic [15:0]       wa;    // alpha * capped factor, 65280 is 1.0
    } fsab_item_t;

    typedef struct packed {
        logic [NUM_CH-1:0] keep;  // stored channels
    } fsab_cfg_t;

    // pixel as a reader sees it: unstored channels read as 0,0,0,255
    function automatic logic [31:0] load_px(input logic [31:0] word,
                                            input logic [NUM_CH-1:0] keep);
        logic [31:0] px;
        for (int c = 0; c < NUM_CH; c++) begin
            if (keep[c]) begin
                px[8*c +: 8] = word[8*c +: 8];
            end else if (c == NUM_CH - 1) begin
                px[8*c +: 8] = ALPHA_OPAQUE;
            end else begin
                px[8*c +: 8] = 8'd0;
            end
        end
        return px;
    endfunction

    // only stored channels replace bytes of the word
    function automatic logic [31:0] merge_px(input logic [31:0] word,
                                             input logic [31:0] px,
                                             input logic [NUM_CH-1:0] keep);
        logic [31:0] res;
        for (int c = 0; c < NUM_CH; c++) begin
            res[8*c +: 8] = keep[c] ? px[8*c +: 8] : word[8*c +: 8];
        end
        return res;
    endfunction

endpackage

// ----- hdl/fsab_front.sv -----
`timescale 1ns / 1ps

module fsab_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output fsab_pkg::fsab_item_t push_item,
    output fsab_pkg::fsab_cfg_t  cfg_out
);
    import fsab_pkg::*;

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [2:0] channels_reg;
    logic [8:0] offset_x_reg;
    logic [8:0] offset_y_reg;
    logic [8:0] factor_reg;

    logic [1:0]        func;
    logic [7:0]        x_in;
    logic [7:0]        y_in;
    logic [7:0]        alpha_in;
    logic [8:0]        off_x;
    logic [8:0]        off_y;
    logic signed [9:0] x_eff;
    logic signed [9:0] y_eff;
    logic [8:0]        w_eff;
    logic [8:0]        h_eff;
    logic              in_image;
    logic [16:0]       row_base;
    logic [16:0]       addr_full;
    logic [8:0]        factor_cap;
    logic [16:0]       wa_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 9'(MAX_WIDTH);
            height_reg   <= 9'(MAX_HEIGHT);
            channels_reg <= 3'(NUM_CH);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            factor_reg   <= FACTOR_ONE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data;
                REG_HEIGHT:   height_reg   <= cfg_data;
                REG_CHANNELS: channels_reg <= cfg_data[2:0];
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                REG_FACTOR:   factor_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            cfg_out.keep[c] = channels_reg > 3'(c);
        end
    end

    assign func     = s_tuser;
    assign x_in     = s_tdata[7:0];
    assign y_in     = s_tdata[15:8];
    assign alpha_in = s_tdata[47:40];

    // offsets only move a blend source
    assign off_x = (func == FUNC_BLEND) ? offset_x_reg : 9'd0;
    assign off_y = (func == FUNC_BLEND) ? offset_y_reg : 9'd0;
    assign x_eff = $signed({2'b00, x_in}) + $signed({off_x[8], off_x});
    assign y_eff = $signed({2'b00, y_in}) + $signed({off_y[8], off_y});

    assign w_eff = (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;

    assign in_image = !x_eff[9] && !y_eff[9] && (x_eff[8:0] < w_eff) && (y_eff[8:0] < h_eff);

    assign row_base  = {9'd0, y_eff[7:0]} * {8'd0, w_eff};
    assign addr_full = row_base + {9'd0, x_eff[7:0]};

    assign factor_cap = (factor_reg > FACTOR_ONE) ? FACTOR_ONE : factor_reg;
    assign wa_full    = {9'd0, alpha_in} * {8'd0, factor_cap};

    always_comb begin
        push_item.addr = addr_full[ADDR_W-1:0];
        push_item.src  = s_tdata[47:16];
        push_item.wa   = wa_full[15:0];
        unique case (func)
            FUNC_WRITE: push_item.op = in_image ? OP_WRITE : OP_DROP;
            FUNC_READ:  push_item.op = in_image ? OP_READ : OP_DROP;
            FUNC_BLEND: push_item.op = in_image ? OP_BLEND : OP_DROP;
            default:    push_item.op = OP_DROP;
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ----- hdl/fsab_queue.sv -----
`timescale 1ns / 1ps

module fsab_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  fsab_pkg::fsab_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output fsab_pkg::fsab_item_t pop_item
);
    import fsab_pkg::*;

    fsab_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/fsab_back.sv -----
`timescale 1ns / 1ps

module fsab_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fsab_pkg::fsab_cfg_t  cfg_in,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  fsab_pkg::fsab_item_t pop_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser
);
    import fsab_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [31:0] frame_mem [MAX_WIDTH * MAX_HEIGHT];

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    fsab_item_t  item_reg;
    logic [31:0] rd_word_reg;
    logic [23:0] num_reg [NUM_CH];
    logic [15:0] quo_reg [NUM_CH];
    logic [7:0]  est_reg [NUM_CH];
    logic [31:0] blend_px_reg;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic              pop_fire;
    logic              out_free;
    logic              done_fire;
    logic [31:0]       dst_px;
    logic [31:0]       new_px;
    logic [31:0]       new_word;
    logic [31:0]       res_px;
    logic              wr_en;
    logic signed [8:0]  diff   [NUM_CH];
    logic [23:0]        base   [NUM_CH];
    logic signed [25:0] num    [NUM_CH];
    logic [16:0]        qsum   [NUM_CH];
    logic [15:0]        rem    [NUM_CH];
    logic [7:0]         px_c   [NUM_CH];

    assign pop_ready = state_reg == ST_IDLE;
    assign pop_fire  = pop_valid && pop_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_fire = (state_reg == ST_DONE) && out_free;

    assign dst_px = load_px(rd_word_reg, cfg_in.keep);

    // n = dst*65280 + (src - dst)*wa, always within 24 bits
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            diff[c] = $signed({1'b0, item_reg.src[8*c +: 8]})
                    - $signed({1'b0, dst_px[8*c +: 8]});
            base[c] = {dst_px[8*c +: 8], 16'd0} - {8'd0, dst_px[8*c +: 8], 8'd0};
            num[c]  = $signed({2'b00, base[c]})
                    + $signed({{17{diff[c][8]}}, diff[c]}) * $signed({9'd0, item_reg.wa});
        end
    end

    // divide by 65280: drop 8 bits, then divide by 255 with one correction
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            qsum[c] = {1'b0, num_reg[c][23:8]} + {9'd0, num_reg[c][23:16]};
            rem[c]  = quo_reg[c] - ({est_reg[c], 8'd0} - {8'd0, est_reg[c]});
            px_c[c] = (rem[c] >= 16'd255) ? est_reg[c] + 8'd1 : est_reg[c];
        end
    end

    always_comb begin
        new_px   = (item_reg.op == OP_BLEND) ? blend_px_reg : item_reg.src;
        new_word = merge_px(rd_word_reg, new_px, cfg_in.keep);
        wr_en    = done_fire && (item_reg.op == OP_WRITE || item_reg.op == OP_BLEND);
        case (item_reg.op)
            OP_READ:  res_px = dst_px;
            OP_BLEND: res_px = load_px(new_word, cfg_in.keep);
            default:  res_px = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_fire) begin
                    state_next = (pop_item.op == OP_DROP) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: state_next = (item_reg.op == OP_BLEND) ? ST_MUL : ST_DONE;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (done_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            item_reg    <= pop_item;
            rd_word_reg <= frame_mem[pop_item.addr];
        end
        if (wr_en) begin
            frame_mem[item_reg.addr] <= new_word;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (state_reg == ST_READ) begin
                num_reg[c] <= num[c][23:0];
            end
            if (state_reg == ST_MUL) begin
                quo_reg[c] <= num_reg[c][23:8];
                est_reg[c] <= qsum[c][15:8];
            end
            if (state_reg == ST_DIV) begin
                blend_px_reg[8*c +: 8] <= px_c[c];
            end
        end
        if (done_fire) begin
            m_tdata_reg <= res_px;
            m_tuser_reg <= item_reg.op == OP_DROP;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hdl/frame_store_alpha_blend.sv -----
`timescale 1ns / 1ps
// a dropped item goes from the back end idle state straight to done; a write or read
// passes through the frame memory read state, a blend through read, multiply and divide
// the back end takes a new item only when idle, after the result of the last one has been
// passed to the output register, so items are handled one at a time
// synchronous active-low reset clears control state, queue and config; frame memory is kept
`include "frame_store_alpha_blend_defines.svh"

module frame_store_alpha_blend (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_pos, y_pos, red, green, blue, alpha
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_tuser    // status
);
    import fsab_pkg::*;

    fsab_item_t push_item;
    fsab_item_t pop_item;
    fsab_cfg_t  cfg_bus;
    logic       q_push_valid;
    logic       q_push_ready;
    logic       q_pop_valid;
    logic       q_pop_ready;

    fsab_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (push_item),
        .cfg_out    (cfg_bus)
    );

    fsab_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (pop_item)
    );

    fsab_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_in    (cfg_bus),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // back end works on one item at a time
    `FSAB_ASSERT_NEXT(a_single_item, q_pop_valid && q_pop_ready, !q_pop_ready)
    // an accepted transaction is visible to the back end in the next cycle
    `FSAB_ASSERT_NEXT(a_push_visible, s_tvalid && s_tready, q_pop_valid)
    // a dropped item carries no color
    `FSAB_ASSERT_NOW(a_drop_zero, m_tvalid && m_tuser, m_tdata == 32'd0)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import fsab_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam int unsigned WEIGHT_ONE = 65280;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] y_pos;
        logic [7:0] x_pos;
    } pixel_op_t;

    typedef struct packed {
        logic        status;
        logic [31:0] color;   // r in bits 7..0 up to a in 31..24
    } pixel_res_t;

    typedef struct {
        bit         is_reg;
        logic [2:0] idx;
        logic [8:0] val;
        pixel_op_t  op;
        bit         typed;
        pixel_res_t want;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // x_pos, y_pos, red, green, blue, alpha
    logic [1:0]  s_tuser = '0;    // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // out_red, out_green, out_blue, out_alpha
    logic        m_tuser;         // status

    frame_store_alpha_blend i_dut (.*);

    // shadow of the frame and of which bytes of each entry hold data
    bit [31:0]   frame_img [MAX_WIDTH*MAX_HEIGHT];
    bit [3:0]    byte_set  [MAX_WIDTH*MAX_HEIGHT];
    logic [8:0]  reg_img   [6];

    pixel_res_t  expected_px [$];
    pixel_res_t  head_px;
    plan_row_t   plan [$];
    int          recent_x [$];
    int          recent_y [$];
    string       chan_name [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

    int          err_cnt = 0;
    int          n_sent = 0;
    int          n_directed = 0;
    int          n_checked = 0;
    int          n_blend = 0;
    int          n_drop = 0;
    int          n_settings = 0;
    int          burst_left = 0;
    int unsigned cycle_cnt = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int eff_width();
        return reg_img[REG_WIDTH] > MAX_WIDTH ? MAX_WIDTH : int'(reg_img[REG_WIDTH]);
    endfunction

    function automatic int eff_height();
        return reg_img[REG_HEIGHT] > MAX_HEIGHT ? MAX_HEIGHT : int'(reg_img[REG_HEIGHT]);
    endfunction

    function automatic int eff_channels();
        return reg_img[REG_CHANNELS] > NUM_CH ? NUM_CH : int'(reg_img[REG_CHANNELS]);
    endfunction

    function automatic int sext9(logic [8:0] v);
        return v[8] ? int'(v) - 512 : int'(v);
    endfunction

    // frame entry hit by an item, blend coordinates moved by the offsets
    function automatic bit locate_op(pixel_op_t op, output int slot);
        int x, y;
        x = int'(op.x_pos);
        y = int'(op.y_pos);
        slot = 0;
        if (op.func == FUNC_BLEND) begin
            x += sext9(reg_img[REG_OFFSET_X]);
            y += sext9(reg_img[REG_OFFSET_Y]);
        end
        if (x < 0 || y < 0 || x >= eff_width() || y >= eff_height()) begin
            return 1'b0;
        end
        slot = y * eff_width() + x;
        return 1'b1;
    endfunction

    function automatic logic [31:0] visible_px(int slot);
        logic [31:0] px;
        px = {ALPHA_OPAQUE, 24'd0};
        for (int c = 0; c < eff_channels(); c++) begin
            px[8*c +: 8] = frame_img[slot][8*c +: 8];
        end
        return px;
    endfunction

    function automatic void store_px(int slot, logic [31:0] px);
        for (int c = 0; c < eff_channels(); c++) begin
            frame_img[slot][8*c +: 8] = px[8*c +: 8];
            byte_set[slot][c] = 1'b1;
        end
    endfunction

    function automatic pixel_res_t predict_pixel(pixel_op_t op);
        pixel_res_t  res;
        int          slot;
        logic [31:0] src, dst, mix;
        int unsigned f, wa, dc, sc;
        res.status = 1'b1;
        res.color = 32'd0;
        src = {op.alpha, op.blue, op.green, op.red};
        if (op.func != FUNC_UNKNOWN && locate_op(op, slot)) begin
            res.status = 1'b0;
            case (op.func)
                FUNC_WRITE: begin
                    store_px(slot, src);
                    recent_x.push_back(int'(op.x_pos));
                    recent_y.push_back(int'(op.y_pos));
                    if (recent_x.size() > 16) begin
                        void'(recent_x.pop_front());
                        void'(recent_y.pop_front());
                    end
                end
                FUNC_READ: begin
                    res.color = visible_px(slot);
                end
                default: begin
                    f = reg_img[REG_FACTOR] > FACTOR_ONE ? 256 : reg_img[REG_FACTOR];
                    wa = op.alpha * f;
                    dst = visible_px(slot);
                    for (int c = 0; c < 4; c++) begin
                        dc = dst[8*c +: 8];
                        sc = src[8*c +: 8];
                        mix[8*c +: 8] = 8'((dc * (WEIGHT_ONE - wa) + sc * wa) / WEIGHT_ONE);
                    end
                    store_px(slot, mix);
                    res.color = visible_px(slot);
                    n_blend++;
                end
            endcase
        end
        if (res.status) begin
            n_drop++;
        end
        return res;
    endfunction

    // true when the item would look at bytes of an entry that hold no data yet
    function automatic bit hits_unset(pixel_op_t op);
        int         slot;
        logic [3:0] need;
        need = 4'((1 << eff_channels()) - 1);
        return locate_op(op, slot) && ((byte_set[slot] & need) != need);
    endfunction

    function automatic pixel_op_t random_pixel_op();
        pixel_op_t op;
        int        pick, k, x, y, w, h;
        bit        placed;
        pick = $urandom_range(0, 99);
        op.func = pick < 35 ? FUNC_WRITE : pick < 65 ? FUNC_READ :
                  pick < 96 ? FUNC_BLEND : FUNC_UNKNOWN;
        op.red = 8'($urandom);
        op.green = 8'($urandom);
        op.blue = 8'($urandom);
        case ($urandom_range(0, 5))
            0: op.alpha = 8'd0;
            1: op.alpha = 8'hff;
            default: op.alpha = 8'($urandom);
        endcase
        placed = 1'b0;
        x = 0;
        y = 0;
        if (recent_x.size() != 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, recent_x.size() - 1);
            x = recent_x[k];
            y = recent_y[k];
            if (op.func == FUNC_BLEND) begin
                x -= sext9(reg_img[REG_OFFSET_X]);
                y -= sext9(reg_img[REG_OFFSET_Y]);
            end
            placed = x >= 0 && x < 256 && y >= 0 && y < 256;
        end
        if (!placed) begin
            w = eff_width();
            h = eff_height();
            x = ($urandom_range(0, 4) == 0 || w >= 255) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, w + 1);
            y = ($urandom_range(0, 4) == 0 || h >= 255) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, h + 1);
        end
        op.x_pos = 8'(x);
        op.y_pos = 8'(y);
        if ((op.func == FUNC_READ || op.func == FUNC_BLEND) && hits_unset(op)) begin
            op.func = FUNC_WRITE;
        end
        return op;
    endfunction

    function automatic logic [8:0] random_dim();
        case ($urandom_range(0, 19))
            0: return 9'd0;
            1, 2: return 9'd1;
            3, 4: return 9'd256;
            5: return 9'd511;
            6: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [8:0] random_offset();
        case ($urandom_range(0, 9))
            0: return 9'h100;
            1: return 9'h0ff;
            2, 3: return 9'($urandom);
            default: return 9'($urandom_range(0, 6) - 3);
        endcase
    endfunction

    function automatic void plan_reg(logic [2:0] idx, logic [8:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.idx = idx;
        row.val = val;
        plan.push_back(row);
    endfunction

    function automatic void plan_op(logic [1:0] func, logic [7:0] x, logic [7:0] y,
                                    logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [7:0] a, bit typed, logic st, logic [31:0] color);
        plan_row_t row;
        row = '{default: '0};
        row.op = '{func: func, alpha: a, blue: b, green: g, red: r, y_pos: y, x_pos: x};
        row.typed = typed;
        row.want = '{status: st, color: color};
        plan.push_back(row);
    endfunction

    task automatic send_pixel_op(pixel_op_t op, bit typed, pixel_res_t want);
        int         gap;
        pixel_res_t got;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {op.alpha, op.blue, op.green, op.red, op.y_pos, op.x_pos};
        s_tuser <= op.func;
        do @(posedge aclk); while (!s_tready);
        got = predict_pixel(op);
        expected_px.push_back(typed ? want : got);
        n_sent++;
    endtask

    // registers change only with the block drained
    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_img[idx] = (idx == REG_CHANNELS) ? {6'd0, val[2:0]} : val;
        n_settings++;
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_px.size());
            $display("frame_store_alpha_blend test failed");
            $finish;
        end
    end

    // receiver stall pattern is picked by bits 10 and 9 of the cycle count
    always @(posedge aclk) begin
        case (cycle_cnt[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 9) < 7);
            2'd2: m_tready <= (cycle_cnt[1:0] == 2'd0);
            default: m_tready <= (cycle_cnt[5:3] != 3'd0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_px.size() == 0) begin
                err_cnt++;
                $display("%0t: result transaction with none expected, actual %h status %0d",
                         $time, m_tdata, m_tuser);
            end else begin
                head_px = expected_px.pop_front();
                n_checked++;
                for (int c = 0; c < 4; c++) begin
                    if (m_tdata[8*c +: 8] !== head_px.color[8*c +: 8]) begin
                        err_cnt++;
                        $display("%0t: %s expected %h actual %h", $time, chan_name[c],
                                 head_px.color[8*c +: 8], m_tdata[8*c +: 8]);
                    end
                end
                if (m_tuser !== head_px.status) begin
                    err_cnt++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             head_px.status, m_tuser);
                end
            end
        end
    end

    initial begin
        reg_img[REG_WIDTH] = 9'd256;
        reg_img[REG_HEIGHT] = 9'd256;
        reg_img[REG_CHANNELS] = 9'd4;
        reg_img[REG_OFFSET_X] = 9'd0;
        reg_img[REG_OFFSET_Y] = 9'd0;
        reg_img[REG_FACTOR] = FACTOR_ONE;

        // reset settings: full image, four channels, factor 1.0
        plan_op(FUNC_WRITE,   0,   0, 8'hff, 8'h00, 8'hff, 8'h00, 1, 0, 32'h0);
        plan_op(FUNC_READ,    0,   0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 32'h00ff00ff);
        plan_op(FUNC_WRITE, 255, 255, 8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 32'h0);
        plan_op(FUNC_READ,  255, 255, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 32'hffffffff);
        plan_op(FUNC_UNKNOWN, 7,   9, 8'ha5, 8'h5a, 8'hc3, 8'h3c, 1, 1, 32'h0);
        plan_op(FUNC_BLEND,   0,   0, 8'h12, 8'h34, 8'h56, 8'h00, 0, 0, 32'h0);
        plan_op(FUNC_BLEND, 255, 255, 8'h00, 8'h00, 8'h00, 8'hff, 0, 0, 32'h0);
        plan_op(FUNC_BLEND,   0,   0, 8'h80, 8'h80, 8'h80, 8'h80, 0, 0, 32'h0);
        // zero and saturated factor
        plan_reg(REG_FACTOR, 9'd0);
        plan_op(FUNC_BLEND, 255, 255, 8'h11, 8'h22, 8'h33, 8'hff, 0, 0, 32'h0);
        plan_reg(REG_FACTOR, 9'd511);
        plan_op(FUNC_BLEND,   0,   0, 8'h40, 8'hc0, 8'h20, 8'hff, 0, 0, 32'h0);
        // small image, edges and outside
        plan_reg(REG_WIDTH, 9'd4);
        plan_reg(REG_HEIGHT, 9'd3);
        plan_op(FUNC_WRITE,   3,   2, 8'h9a, 8'hbc, 8'hde, 8'hf0, 1, 0, 32'h0);
        plan_op(FUNC_WRITE,   4,   0, 8'h01, 8'h02, 8'h03, 8'h04, 1, 1, 32'h0);
        plan_op(FUNC_WRITE,   0,   3, 8'h05, 8'h06, 8'h07, 8'h08, 1, 1, 32'h0);
        plan_op(FUNC_READ,    3,   2, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 32'h0);
        plan_op(FUNC_READ,  255, 255, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 32'h0);
        // negative and positive offsets on blend
        plan_reg(REG_OFFSET_X, 9'h1ff);
        plan_reg(REG_OFFSET_Y, 9'h0ff);
        plan_op(FUNC_BLEND,   4,   0, 8'h01, 8'h02, 8'h03, 8'h04, 1, 1, 32'h0);
        plan_reg(REG_OFFSET_Y, 9'h1ff);
        plan_op(FUNC_BLEND,   4,   3, 8'h00, 8'hff, 8'h80, 8'h7f, 0, 0, 32'h0);
        plan_op(FUNC_BLEND,   0,   0, 8'hff, 8'hff, 8'hff, 8'hff, 1, 1, 32'h0);
        plan_reg(REG_OFFSET_X, 9'h100);
        plan_op(FUNC_BLEND, 255,   3, 8'hff, 8'hff, 8'hff, 8'hff, 1, 1, 32'h0);
        // no stored channel, then two
        plan_reg(REG_CHANNELS, 9'd0);
        plan_op(FUNC_READ,    3,   2, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 32'hff000000);
        plan_op(FUNC_WRITE,   0,   0, 8'h55, 8'h55, 8'h55, 8'h55, 1, 0, 32'h0);
        plan_reg(REG_CHANNELS, 9'd2);
        plan_op(FUNC_WRITE,   1,   1, 8'h11, 8'h22, 8'h33, 8'h44, 1, 0, 32'h0);
        plan_op(FUNC_READ,    1,   1, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 32'h0);
        // channel count above four, zero width
        plan_reg(REG_CHANNELS, 9'd7);
        plan_reg(REG_WIDTH, 9'd0);
        plan_op(FUNC_READ,    0,   0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 32'h0);
        plan_op(FUNC_WRITE,   0,   0, 8'h99, 8'h88, 8'h77, 8'h66, 1, 1, 32'h0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_pixel_op(plan[i].op, plan[i].typed, plan[i].want);
            end
        end
        n_directed = n_sent;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 1) begin
                write_reg(REG_WIDTH, 9'd511);
                write_reg(REG_HEIGHT, 9'd511);
                write_reg(REG_CHANNELS, 9'd7);
                write_reg(REG_OFFSET_X, 9'h0ff);
                write_reg(REG_OFFSET_Y, 9'h000);
                write_reg(REG_FACTOR, 9'h1ff);
            end else begin
                write_reg(REG_WIDTH, random_dim());
                write_reg(REG_HEIGHT, random_dim());
                write_reg(REG_CHANNELS, $urandom_range(0, 1) ? 9'd4 : 9'($urandom_range(0, 7)));
                write_reg(REG_OFFSET_X, random_offset());
                write_reg(REG_OFFSET_Y, random_offset());
                case ($urandom_range(0, 5))
                    0: write_reg(REG_FACTOR, 9'd0);
                    1: write_reg(REG_FACTOR, FACTOR_ONE);
                    2: write_reg(REG_FACTOR, 9'd511);
                    3: write_reg(REG_FACTOR, 9'($urandom_range(257, 511)));
                    default: write_reg(REG_FACTOR, 9'($urandom_range(0, 256)));
                endcase
            end
            // pixel positions change meaning with the image width
            recent_x.delete();
            recent_y.delete();
            repeat (PHASE_ITEMS) send_pixel_op(random_pixel_op(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d pixel transactions (%0d directed) under %0d register writes",
                 n_sent, n_directed, n_settings);
        $display("%0d results checked, %0d blends landed in the image, %0d items dropped",
                 n_checked, n_blend, n_drop);
        if (err_cnt == 0) begin
            $display("frame_store_alpha_blend test passed");
        end else begin
            $display("frame_store_alpha_blend test failed");
        end
        $finish;
    end

endmodule
